@@ design/drc_pkg.sv @@
// ----------------------------------------------------------------------------
// drc_pkg
// types, constants and constant tables shared by the compressor files
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

    localparam int SAMPLE_W = 24;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [23:0]         coeff_t;
    typedef logic [14:0]         db_t;
    typedef logic [15:0]         ratio_t;
    typedef logic [13:0]         makeup_t;
    typedef logic [12:0]         gain_t;
    typedef logic [2:0]          cfg_idx_t;
    typedef logic [23:0]         cfg_data_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_ATTACK  = 3'd0;
    localparam cfg_idx_t CFG_RELEASE = 3'd1;
    localparam cfg_idx_t CFG_THRESH  = 3'd2;
    localparam cfg_idx_t CFG_RATIO   = 3'd3;
    localparam cfg_idx_t CFG_KNEE    = 3'd4;
    localparam cfg_idx_t CFG_MAKEUP  = 3'd5;
    localparam cfg_idx_t CFG_SOFT    = 3'd6;

    // reset values of the configuration registers
    localparam coeff_t  RST_ATTACK  = 24'd16358000;
    localparam coeff_t  RST_RELEASE = 24'd16769000;
    localparam db_t     RST_THRESH  = 15'h7400;
    localparam ratio_t  RST_RATIO   = 16'd8192;
    localparam db_t     RST_KNEE    = 15'd2560;
    localparam makeup_t RST_MAKEUP  = 14'd4096;

    localparam sample_t HALF_SCALE = 24'h80_0000;
    localparam gain_t   UNITY_GAIN = 13'd4096;
    localparam logic [15:0] Q15_ONE  = 16'd32768;
    localparam logic [31:0] DB_SCALE  = 32'd394566;   // 20*log10(2) in Q.16
    localparam logic [31:0] EXP_SCALE = 32'd2786635;  // log2(10)/20 scaled
    localparam logic [23:0] FLOOR_DB  = 24'd24576;    // 96 dB in Q8.8

    typedef logic [15:0][29:0] root_tbl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_NORM,
        ST_LOG_SQ,
        ST_LOG_ACC,
        ST_DB_MUL,
        ST_DB_CHK,
        ST_HARD_MUL,
        ST_HARD_RND,
        ST_SQ_X,
        ST_SQ_S,
        ST_SQ_N,
        ST_DIV,
        ST_P_MUL,
        ST_P_RND,
        ST_EXP_MUL,
        ST_EXP_UPD,
        ST_EXP_FIN,
        ST_OUT_GM,
        ST_OUT_MAG,
        ST_OUT_RND
    } state_t;

    // floor integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] one;
        logic [63:0] rem;
        res = '0;
        one = 64'h4000_0000_0000_0000;
        rem = n;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + one)
            begin
                rem = rem - (res + one);
                res = (res >> 1) + one;
            end
            else
            begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // entry k holds 2^-(2^-(k+1)) in Q.30, by repeated roots of one half
    function automatic root_tbl_t exp_roots();
        root_tbl_t   tbl;
        logic [63:0] root;
        tbl  = '0;
        root = 64'h2000_0000;
        for (int k = 0; k < 16; k++)
        begin
            root   = isqrt64(root << 30);
            tbl[k] = root[29:0];
        end
        return tbl;
    endfunction

    localparam root_tbl_t EXP_ROOTS = exp_roots();

endpackage

`default_nettype wire

@@ design/drc_if.sv @@
// ----------------------------------------------------------------------------
// drc_in_if / drc_out_if
// valid/ready channels carrying input and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface drc_in_if;
    logic             valid;
    logic             ready;
    logic             channel;
    drc_pkg::sample_t sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface drc_out_if;
    logic             valid;
    logic             ready;
    logic             channel_out;
    drc_pkg::sample_t sample_out;
    drc_pkg::gain_t   gain_applied;

    modport source (output valid, output channel_out, output sample_out,
                    output gain_applied, input ready);
    modport sink   (input valid, input channel_out, input sample_out,
                    input gain_applied, output ready);
endinterface

`default_nettype wire

@@ design/dynamic_range_compressor.sv @@
// ----------------------------------------------------------------------------
// dynamic_range_compressor
// per-channel peak follower, log level, hard/soft knee gain computer,
// exp gain and makeup, all on one shared 32x32 multiplier
// ----------------------------------------------------------------------------
// paths: a zero envelope goes straight to the output multiplies, the longest
//   path is a 23-step normalization, 16 log squarings, the 16-step knee division
//   and the 16 exp multiplies, each run one step a cycle on the shared
//   multiplier / subtractor
// throughput: one word at a time; din.ready is high only while idle, and a
//   finished result waits in the output register while the next word enters
// reset: rst_n clears the control state, the envelopes and restores the
//   configuration register defaults
`default_nettype none

module dynamic_range_compressor #(
    parameter int CHANNELS = 2
) (
    input  wire                  clk,
    input  wire                  rst_n,
    drc_in_if.sink               din,
    drc_out_if.source            dout,
    input  wire                  cfg_we,
    input  drc_pkg::cfg_idx_t    cfg_index,
    input  drc_pkg::cfg_data_t   cfg_data
);
    import drc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration registers
    coeff_t  attack_reg;
    coeff_t  release_reg;
    db_t     thr_reg;
    ratio_t  ratio_reg;
    db_t     knee_reg;
    makeup_t makeup_reg;
    logic    soft_reg;

    // envelope store, one per channel
    sample_t env_mem [CHANNELS];
    logic    env_we;

    state_t state_reg, state_next;

    logic              ch_reg, ch_next;
    logic              neg_reg, neg_next;
    sample_t           a_reg, a_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    sample_t           env_reg, env_next;      // envelope, then normalized mantissa
    logic [4:0]        s_reg, s_next;          // normalization shift count
    logic [31:0]       m_reg, m_next;          // log mantissa, then exp value
    logic [15:0]       frac_reg, frac_next;    // log fraction, then exp fraction
    logic [3:0]        k_reg, k_next;
    logic [63:0]       prod_reg;
    logic [16:0]       red_reg, red_next;      // reduction, also quotient
    logic [16:0]       opnd_reg, opnd_next;    // positive excess or knee x
    logic [6:0]        ip_reg, ip_next;
    gain_t             gain_reg, gain_next;
    logic [49:0]       rem_reg, rem_next;
    logic [49:0]       dv_reg, dv_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_ch_reg, out_ch_next;
    sample_t           out_sample_reg, out_sample_next;
    gain_t             out_gain_reg, out_gain_next;

    // shared multiplier
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic              mul_en;

    // decisions used by both the sequencer and the datapath
    logic              in_fire;
    logic              env_up;
    logic [47:0]       env_rsum;
    logic [24:0]       env_sum;
    sample_t           env_new;
    logic [47:0]       db_sum;
    logic [23:0]       db_mag;
    logic              db_floor;
    logic signed [19:0] d_val;
    logic signed [19:0] d2;
    logic signed [19:0] w_s;
    logic              knee_on;
    logic              below_knee;
    logic              in_knee;
    logic [16:0]       knee_x;
    logic [15:0]       slope;
    logic [31:0]       v_sh;
    logic [31:0]       g_sum;
    logic [51:0]       mag_sum;
    logic [27:0]       mag;
    sample_t           sat_mag;
    logic              out_load;

    assign in_fire = din.valid && din.ready;
    assign din.ready = (state_reg == ST_IDLE);

    assign dout.valid        = out_valid_reg;
    assign dout.channel_out  = out_ch_reg;
    assign dout.sample_out   = out_sample_reg;
    assign dout.gain_applied = out_gain_reg;

    // envelope step: a -/+ round(coeff*|a-env|)
    assign env_up   = a_reg > env_reg;
    assign env_rsum = prod_reg[47:0] + 48'h80_0000;
    assign env_sum  = env_up ? (25'(a_reg) - 25'(env_rsum[47:24]))
                             : (25'(a_reg) + 25'(env_rsum[47:24]));
    assign env_new  = (env_sum > 25'(HALF_SCALE)) ? HALF_SCALE : env_sum[23:0];

    // level in dB and distance to the threshold
    assign db_sum   = prod_reg[47:0] + 48'h80_0000;
    assign db_mag   = db_sum[47:24];
    assign db_floor = db_mag >= FLOOR_DB;
    assign d_val    = $signed(20'd0) - $signed({3'b000, db_mag[16:0]})
                      - $signed({{5{thr_reg[14]}}, thr_reg});
    assign d2       = {d_val[18:0], 1'b0};
    assign w_s      = $signed({5'b00000, knee_reg});
    assign knee_on  = soft_reg && (knee_reg != '0);
    assign below_knee = d2 < -w_s;
    assign in_knee  = d2 <= w_s;
    assign knee_x   = 17'(d2 + w_s);
    assign slope    = ratio_reg[15] ? 16'd0 : (Q15_ONE - ratio_reg);

    // exp final scaling and output rounding
    assign v_sh    = (ip_reg >= 7'd31) ? 32'd0 : (m_reg >> ip_reg[4:0]);
    assign g_sum   = v_sh + 32'h0002_0000;
    assign mag_sum = prod_reg[51:0] + 52'h80_0000;
    assign mag     = mag_sum[51:24];
    assign out_load = (state_reg == ST_OUT_RND) && (!out_valid_reg || dout.ready);

    always_comb
    begin
        if (neg_reg)
            sat_mag = (mag > 28'(HALF_SCALE)) ? HALF_SCALE : mag[23:0];
        else
            sat_mag = (mag > 28'(HALF_SCALE - 24'd1)) ? (HALF_SCALE - 24'd1) : mag[23:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire) state_next = ST_ENV_MUL;
            ST_ENV_MUL:  state_next = ST_ENV_UPD;
            ST_ENV_UPD:  state_next = (env_new == '0) ? ST_OUT_GM : ST_NORM;
            ST_NORM:     if (env_reg[23]) state_next = ST_LOG_SQ;
            ST_LOG_SQ:   state_next = ST_LOG_ACC;
            ST_LOG_ACC:  state_next = (k_reg == 4'd15) ? ST_DB_MUL : ST_LOG_SQ;
            ST_DB_MUL:   state_next = ST_DB_CHK;
            ST_DB_CHK:
            begin
                if (db_floor)
                    state_next = ST_OUT_GM;
                else if (knee_on && below_knee)
                    state_next = ST_P_MUL;
                else if (knee_on && in_knee)
                    state_next = ST_SQ_X;
                else if (d_val > 0)
                    state_next = ST_HARD_MUL;
                else
                    state_next = ST_P_MUL;
            end
            ST_HARD_MUL: state_next = ST_HARD_RND;
            ST_HARD_RND: state_next = ST_P_MUL;
            ST_SQ_X:     state_next = ST_SQ_S;
            ST_SQ_S:     state_next = ST_SQ_N;
            ST_SQ_N:     state_next = ST_DIV;
            ST_DIV:      if (k_reg == 4'd15) state_next = ST_P_MUL;
            ST_P_MUL:    state_next = ST_P_RND;
            ST_P_RND:    state_next = ST_EXP_MUL;
            ST_EXP_MUL:  state_next = ST_EXP_UPD;
            ST_EXP_UPD:  state_next = (k_reg == 4'd15) ? ST_EXP_FIN : ST_EXP_MUL;
            ST_EXP_FIN:  state_next = ST_OUT_GM;
            ST_OUT_GM:   state_next = ST_OUT_MAG;
            ST_OUT_MAG:  state_next = ST_OUT_RND;
            ST_OUT_RND:  if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and multiplier operand selection
    always_comb
    begin
        ch_next    = ch_reg;
        neg_next   = neg_reg;
        a_next     = a_reg;
        idx_next   = idx_reg;
        env_next   = env_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        k_next     = k_reg;
        red_next   = red_reg;
        opnd_next  = opnd_reg;
        ip_next    = ip_reg;
        gain_next  = gain_reg;
        rem_next   = rem_reg;
        dv_next    = dv_reg;
        env_we     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        mul_en     = 1'b0;
        out_ch_next     = out_ch_reg;
        out_sample_next = out_sample_reg;
        out_gain_next   = out_gain_reg;
        out_valid_next  = out_valid_reg;
        if (dout.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ch_next  = din.channel;
                    neg_next = din.sample_in[SAMPLE_W-1];
                    a_next   = din.sample_in[SAMPLE_W-1] ? (~din.sample_in + 24'd1)
                                                         : din.sample_in;
                    idx_next = (CHANNELS > 1) ? IDX_W'(din.channel) : '0;
                    env_next = env_mem[(CHANNELS > 1) ? IDX_W'(din.channel) : '0];
                end
            end
            ST_ENV_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(env_up ? attack_reg : release_reg);
                mul_b  = 32'(env_up ? (a_reg - env_reg) : (env_reg - a_reg));
            end
            ST_ENV_UPD:
            begin
                env_we    = 1'b1;
                env_next  = env_new;
                s_next    = '0;
                gain_next = UNITY_GAIN;
            end
            ST_NORM:
            begin
                if (env_reg[23])
                begin
                    m_next    = {env_reg, 8'h00};
                    k_next    = '0;
                    frac_next = '0;
                end
                else
                begin
                    env_next = {env_reg[22:0], 1'b0};
                    s_next   = s_reg + 5'd1;
                end
            end
            ST_LOG_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = m_reg;
                mul_b  = m_reg;
            end
            ST_LOG_ACC:
            begin
                if (prod_reg[63])
                begin
                    m_next    = prod_reg[63:32];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = prod_reg[62:31];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                k_next = k_reg + 4'd1;
            end
            ST_DB_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = 32'({s_reg, 16'h0000}) - 32'(frac_reg);
                mul_b  = DB_SCALE;
            end
            ST_DB_CHK:
            begin
                red_next  = '0;
                gain_next = UNITY_GAIN;
                if (knee_on && !below_knee && in_knee)
                    opnd_next = knee_x;
                else
                    opnd_next = d_val[16:0];
            end
            ST_HARD_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(opnd_reg);
                mul_b  = 32'(slope);
            end
            ST_HARD_RND:
            begin
                red_next = 17'((prod_reg[33:0] + 34'd16384) >> 15);
            end
            ST_SQ_X:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(opnd_reg);
                mul_b  = 32'(opnd_reg);
            end
            ST_SQ_S:
            begin
                mul_en = 1'b1;
                mul_a  = prod_reg[31:0];
                mul_b  = 32'(slope);
            end
            ST_SQ_N:
            begin
                // numerator plus half the divisor, divisor is width * 2^18
                rem_next = 50'(prod_reg[47:0]) + 50'({knee_reg, 17'h00000});
                dv_next  = 50'({knee_reg, 33'h0});
                red_next = '0;
                k_next   = '0;
            end
            ST_DIV:
            begin
                if (rem_reg >= dv_reg)
                begin
                    rem_next = rem_reg - dv_reg;
                    red_next = {red_reg[15:0], 1'b1};
                end
                else
                begin
                    red_next = {red_reg[15:0], 1'b0};
                end
                dv_next = dv_reg >> 1;
                k_next  = k_reg + 4'd1;
            end
            ST_P_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(red_reg);
                mul_b  = EXP_SCALE;
            end
            ST_P_RND:
            begin
                frac_next = 16'((prod_reg[38:0] + 39'h8000) >> 16);
                ip_next   = 7'((prod_reg[38:0] + 39'h8000) >> 32);
                m_next    = 32'h4000_0000;
                k_next    = '0;
            end
            ST_EXP_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = m_reg;
                mul_b  = 32'(EXP_ROOTS[k_reg]);
            end
            ST_EXP_UPD:
            begin
                // fraction bits are taken msb first
                if (frac_reg[~k_reg])
                    m_next = prod_reg[61:30];
                k_next = k_reg + 4'd1;
            end
            ST_EXP_FIN:
            begin
                gain_next = g_sum[30:18];
            end
            ST_OUT_GM:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(gain_reg);
                mul_b  = 32'(makeup_reg);
            end
            ST_OUT_MAG:
            begin
                mul_en = 1'b1;
                mul_a  = 32'(a_reg);
                mul_b  = 32'(prod_reg[26:0]);
            end
            ST_OUT_RND:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_ch_next     = ch_reg;
                    out_sample_next = neg_reg ? (~sat_mag + 24'd1) : sat_mag;
                    out_gain_next   = gain_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state and envelopes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
                env_mem[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (env_we)
                env_mem[idx_reg] <= env_new;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= RST_ATTACK;
            release_reg <= RST_RELEASE;
            thr_reg     <= RST_THRESH;
            ratio_reg   <= RST_RATIO;
            knee_reg    <= RST_KNEE;
            makeup_reg  <= RST_MAKEUP;
            soft_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ATTACK:  attack_reg  <= cfg_data[23:0];
                CFG_RELEASE: release_reg <= cfg_data[23:0];
                CFG_THRESH:  thr_reg     <= cfg_data[14:0];
                CFG_RATIO:   ratio_reg   <= cfg_data[15:0];
                CFG_KNEE:    knee_reg    <= cfg_data[14:0];
                CFG_MAKEUP:  makeup_reg  <= cfg_data[13:0];
                CFG_SOFT:    soft_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        neg_reg        <= neg_next;
        a_reg          <= a_next;
        idx_reg        <= idx_next;
        env_reg        <= env_next;
        s_reg          <= s_next;
        m_reg          <= m_next;
        frac_reg       <= frac_next;
        k_reg          <= k_next;
        red_reg        <= red_next;
        opnd_reg       <= opnd_next;
        ip_reg         <= ip_next;
        gain_reg       <= gain_next;
        rem_reg        <= rem_next;
        dv_reg         <= dv_next;
        out_ch_reg     <= out_ch_next;
        out_sample_reg <= out_sample_next;
        out_gain_reg   <= out_gain_next;
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_dynamic_range_compressor.sv @@
// ----------------------------------------------------------------------------
// tb_dynamic_range_compressor
// self-checking bench: random and directed sample words go through the
// compressor under several register settings; a bit-exact predictor of
// envelope, log level, knee and exp gain checks every result word
// ----------------------------------------------------------------------------
module tb_dynamic_range_compressor;
    timeunit 1ns;
    timeprecision 1ps;

    import drc_pkg::*;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int SETTLE_WAIT = 200;

    typedef struct packed {
        logic    channel;
        sample_t sample;
    } in_word_t;

    typedef struct packed {
        logic    channel;
        sample_t sample;
        gain_t   gain;
    } out_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    drc_in_if  din_if();
    drc_out_if dout_if();

    dynamic_range_compressor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_if),
        .dout      (dout_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // words waiting to be sent, and results still owed by the block
    in_word_t  send_queue[$];
    out_word_t owed_results[$];

    // predictor copy of the registers and the envelopes
    logic [63:0] p_attack;
    logic [63:0] p_release;
    longint      p_thresh;
    logic [63:0] p_inv_ratio;
    logic [63:0] p_knee;
    logic [63:0] p_makeup;
    logic        p_soft;
    logic [63:0] p_env[2];

    bit idle_on;
    bit failed;
    int gap_left;
    int stall_left;
    int cycles;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] one;
        res = 0;
        one = 64'h4000_0000_0000_0000;
        while (one > n)
        begin
            one = one >> 2;
        end
        while (one != 0)
        begin
            if (n >= res + one)
            begin
                n   = n - (res + one);
                res = (res >> 1) + one;
            end
            else
            begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // |log2(env / full scale)| in Q.16
    function automatic logic [63:0] level_log2(input logic [63:0] env);
        int          n;
        logic [63:0] m;
        logic [63:0] frac;
        longint      l2;
        n = 0;
        while (n < 63 && (env >> (n + 1)) != 0)
        begin
            n++;
        end
        m    = env << (31 - n);
        frac = 0;
        for (int k = 0; k < 16; k++)
        begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        l2 = longint'(n - 23) * 65536 + longint'(frac);
        return 64'(-l2);
    endfunction

    // 2^(-p/65536) in Q1.12
    function automatic logic [63:0] gain_from_exp(input logic [63:0] p);
        logic [63:0] ip;
        logic [63:0] f;
        logic [63:0] v;
        logic [63:0] root;
        ip   = p >> 16;
        f    = p & 64'hFFFF;
        v    = 64'd1 << 30;
        root = 64'd1 << 29;
        for (int k = 1; k <= 16; k++)
        begin
            root = floor_sqrt(root << 30);
            if ((f >> (16 - k)) & 64'd1)
                v = (v * root) >> 30;
        end
        if (ip >= 31)
            v = 0;
        else
            v = v >> ip;
        return (v + (64'd1 << 17)) >> 18;
    endfunction

    // envelope update and gain computer for one accepted word
    function automatic out_word_t predict_compressed(input in_word_t w);
        out_word_t   r;
        logic        neg;
        logic [63:0] raw;
        logic [63:0] a;
        logic [63:0] env;
        logic [63:0] gain;
        logic [63:0] mag;
        logic [63:0] y;
        logic [63:0] slope;
        logic [63:0] red;
        logic [63:0] x;
        logic [63:0] den;
        longint      det;
        longint      d;
        longint      kw;
        bit          hard;
        raw  = 64'(w.sample);
        neg  = w.sample[23];
        a    = neg ? ((64'd1 << 24) - raw) : raw;
        env  = p_env[w.channel];
        gain = 4096;
        if (a > env)
            env = a - ((p_attack * (a - env) + (64'd1 << 23)) >> 24);
        else
            env = a + ((p_release * (env - a) + (64'd1 << 23)) >> 24);
        if (env > 64'h80_0000)
            env = 64'h80_0000;
        p_env[w.channel] = env;

        if (env != 0)
        begin
            det = -longint'((level_log2(env) * 394566 + (64'd1 << 23)) >> 24);
            // below the -96 dB floor the gain stays at unity
            if (det > -24576)
            begin
                d     = det - p_thresh;
                kw    = longint'(p_knee);
                // inverse ratio above one means no compression
                slope = 32768 - ((p_inv_ratio > 32768) ? 64'd32768 : p_inv_ratio);
                red   = 0;
                hard  = 1;
                // a zero knee width falls back to the hard knee
                if (p_soft && kw != 0)
                begin
                    if (2 * d < -kw)
                    begin
                        hard = 0;
                    end
                    else if (2 * d <= kw)
                    begin
                        x    = 64'(2 * d + kw);
                        den  = 64'(kw) * 8 * 32768;
                        hard = 0;
                        red  = (slope * x * x + den / 2) / den;
                    end
                end
                if (hard && d > 0)
                    red = (64'(d) * slope + 16384) >> 15;
                gain = gain_from_exp((red * 2786635 + 32768) >> 16);
            end
        end

        mag = (a * gain * p_makeup + (64'd1 << 23)) >> 24;
        if (neg)
            y = (mag > 64'h80_0000) ? 64'h80_0000 : mag;
        else
            y = (mag > 64'h7F_FFFF) ? 64'h7F_FFFF : mag;
        if (neg)
            y = ((64'd1 << 24) - y);
        r.channel = w.channel;
        r.sample  = y[23:0];
        r.gain    = gain[12:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset and run limit
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input driver: one word at a time from send_queue, random gaps
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din_if.valid     <= 1'b0;
            din_if.channel   <= 1'b0;
            din_if.sample_in <= '0;
            gap_left         <= 0;
        end
        else
        begin
            // accepted word: work out what the block must return
            if (din_if.valid && din_if.ready)
                owed_results.push_back(predict_compressed({din_if.channel, din_if.sample_in}));

            if (din_if.valid && !din_if.ready)
            begin
                // hold the word until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left     <= gap_left - 1;
                din_if.valid <= 1'b0;
            end
            else if (send_queue.size() != 0 && idle_on && $urandom_range(0, 7) == 0)
            begin
                gap_left     <= $urandom_range(0, 12);
                din_if.valid <= 1'b0;
            end
            else if (send_queue.size() != 0)
            begin
                in_word_t w;
                w = send_queue.pop_front();
                din_if.valid     <= 1'b1;
                din_if.channel   <= w.channel;
                din_if.sample_in <= w.sample;
            end
            else
            begin
                din_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor with random back-pressure
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result word with nothing expected: ch %0d sample %0h gain %0d",
                           dout_if.channel_out, dout_if.sample_out, dout_if.gain_applied);
                    failed = 1;
                end
                else
                begin
                    out_word_t e;
                    e = owed_results.pop_front();
                    if (dout_if.channel_out !== e.channel)
                    begin
                        $error("channel_out: expected %0d, got %0d", e.channel,
                               dout_if.channel_out);
                        failed = 1;
                    end
                    if (dout_if.sample_out !== e.sample)
                    begin
                        $error("sample_out: expected %0h, got %0h", e.sample,
                               dout_if.sample_out);
                        failed = 1;
                    end
                    if (dout_if.gain_applied !== e.gain)
                    begin
                        $error("gain_applied: expected %0d, got %0d", e.gain,
                               dout_if.gain_applied);
                        failed = 1;
                    end
                end
            end

            if (stall_left > 0)
            begin
                stall_left    <= stall_left - 1;
                dout_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left    <= $urandom_range(0, 12);
                dout_if.ready <= 1'b0;
            end
            else
            begin
                dout_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // wait until the block has nothing in flight, then let it settle
    task automatic drain_block();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (send_queue.size() != 0 || din_if.valid || owed_results.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // write all seven registers, block idle; predictor follows
    task automatic load_settings(input logic [23:0] att, input logic [23:0] rel,
                                 input longint thr, input logic [15:0] inv,
                                 input logic [14:0] kw, input logic [13:0] mk,
                                 input logic knee_sel);
        cfg_idx_t    idx[7];
        cfg_data_t   val[7];
        logic [14:0] thr_bits;
        thr_bits = 15'(thr);
        idx = '{CFG_ATTACK, CFG_RELEASE, CFG_THRESH, CFG_RATIO, CFG_KNEE, CFG_MAKEUP,
                CFG_SOFT};
        val = '{att, rel, 24'(thr_bits), 24'(inv), 24'(kw), 24'(mk), 24'(knee_sel)};
        for (int i = 0; i < 7; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
        end
        @(posedge clk);
        cfg_we      <= 1'b0;
        p_attack    = att;
        p_release   = rel;
        p_thresh    = thr;
        p_inv_ratio = inv;
        p_knee      = kw;
        p_makeup    = mk;
        p_soft      = knee_sel;
    endtask

    task automatic queue_word(input logic ch, input logic [23:0] s);
        in_word_t w;
        w.channel = ch;
        w.sample  = s;
        send_queue.push_back(w);
    endtask

    // bursts on one channel at a held level, so envelopes settle and the knee
    // sees a steady level; some words are full-range noise
    task automatic queue_random(input int count);
        int          left;
        int          burst;
        int          kind;
        logic        ch;
        logic [23:0] lvl;
        logic [23:0] s;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            ch    = 1'($urandom_range(0, 1));
            kind  = $urandom_range(0, 9);
            lvl   = (kind < 4) ? 24'($urandom_range(24'h10_0000, 24'h7F_FFFF))
                  : (kind < 6) ? 24'($urandom_range(24'h100, 24'hF_FFFF))
                  :              24'($urandom_range(0, 24'hFF));
            for (int i = 0; i < burst && left > 0; i++)
            begin
                if (kind == 9)
                    s = 24'($urandom);
                else
                begin
                    s = lvl ^ 24'($urandom_range(0, 255));
                    s[23] = 1'b0;
                    if ($urandom_range(0, 1))
                        s = -s;
                end
                queue_word(ch, s);
                left--;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ATTACK;
        cfg_data  <= '0;
        idle_on   = 1;
        failed    = 0;
        cycles    = 0;
        p_attack    = 16358000;
        p_release   = 16769000;
        p_thresh    = -3072;
        p_inv_ratio = 8192;
        p_knee      = 2560;
        p_makeup    = 4096;
        p_soft      = 0;
        p_env[0]    = 0;
        p_env[1]    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, field extremes, floor and full-scale words
        queue_word(0, 24'h00_0000);
        queue_word(1, 24'h00_0000);
        queue_word(0, 24'h00_0001);
        queue_word(1, 24'hFF_FFFF);
        queue_word(0, 24'h7F_FFFF);
        queue_word(0, 24'h80_0000);
        queue_word(1, 24'h80_0000);
        queue_word(1, 24'h7F_FFFF);
        for (int i = 0; i < 6; i++)
            queue_word(1'(i % 2), 24'h80_0000);
        queue_word(0, 24'h40_0000);
        queue_word(1, 24'hC0_0000);
        queue_word(0, 24'h00_0010);
        queue_word(1, 24'h55_5555);
        queue_word(0, 24'hAA_AAAA);
        drain_block();

        // fastest follower, deepest threshold, strongest ratio, soft knee
        load_settings(24'd0, 24'd0, -15360, 16'd1638, 15'd256, 14'd16306, 1'b1);
        queue_word(0, 24'h80_0000);
        queue_word(1, 24'h7F_FFFF);
        queue_word(0, 24'h00_0001);
        queue_random(50);
        drain_block();

        // slowest follower, threshold at 0 dB, no compression, widest knee
        load_settings(24'hFF_FFFF, 24'hFF_FFFF, 0, 16'd32768, 15'd20480, 14'd409, 1'b0);
        queue_random(40);
        drain_block();

        // inverse ratio above one and a soft knee of zero width
        load_settings(24'd8_000_000, 24'd12_000_000, -6000, 16'hFFFF, 15'd0, 14'h3FFF,
                      1'b1);
        queue_random(40);
        drain_block();

        // wide soft knee centered near typical levels
        load_settings(24'd10_000_000, 24'd14_000_000, -2000, 16'd4000, 15'd12000,
                      14'd8000, 1'b1);
        queue_random(50);
        drain_block();

        for (int ph = 0; ph < 5; ph++)
        begin
            load_settings(24'($urandom), 24'($urandom), -longint'($urandom_range(0, 15360)),
                          16'($urandom_range(1638, 32768)), 15'($urandom_range(256, 20480)),
                          14'($urandom_range(409, 16306)), 1'($urandom));
            // last phase runs without idling on either side
            if (ph == 4)
                idle_on = 0;
            queue_random(50);
            drain_block();
        end

        if (!failed)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
